/* hw/rtl/lldu_pkg.sv */
package lldu_pkg;

   localparam int MAX_SERVERS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int RESULT_LIMIT    = 16;

   localparam int SRV_IDX_W = 4;   // holds any server index up to the largest server count
   localparam int SRV_CNT_W = 5;   // holds a server count up to the largest server count
   localparam int NSRV_W    = 4;
   localparam int LOAD_W    = 32;
   localparam int ID_W      = 16;
   localparam int TIME_W    = 16;
   localparam int KIND_W    = 2;
   localparam int SRV_NUM_W = 3;
   localparam int EMIT_W    = $clog2(RESULT_LIMIT);

   localparam logic [NSRV_W-1:0] NUM_SERVERS_RST = 4'd8;

   localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DRAINED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd3;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [TIME_W-1:0] job_time;
      logic [ID_W-1:0]   customer_id;
      logic [2:0]        server_index;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [SRV_NUM_W-1:0] server_number;
      logic [ID_W-1:0]      job_id;
      logic [LOAD_W-1:0]    server_load;
      logic                 last;
   } rsp_item_type;

   // broadcast from the sequencer to the row of cells
   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [SRV_IDX_W-1:0] sel;
      logic [ID_W-1:0]      wdata;
      logic [LOAD_W-1:0]    new_load;
   } cell_ctl_type;

   // what one cell shows to the sequencer
   typedef struct packed {
      logic [LOAD_W-1:0] load;
      logic              full;
      logic              empty;
      logic              one;
      logic [ID_W-1:0]   rdata;
   } cell_stat_type;

   // running minimum handed from cell to cell
   typedef struct packed {
      logic [SRV_IDX_W-1:0] idx;
      logic [LOAD_W-1:0]    load;
   } best_type;

endpackage

/* hw/rtl/lldu_cell.sv */
module lldu_cell
   import lldu_pkg::*;
#(
   parameter int CELL_IDX    = 0,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SRV_CNT_W-1:0] active_count,
   input  cell_ctl_type         ctl,
   input  best_type             best_prev,
   output best_type             best_out,
   output cell_stat_type        stat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SRV_IDX_W-1:0] MY_IDX = SRV_IDX_W'(CELL_IDX);

   logic [ID_W-1:0]   queue_mem_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]   rd_ff;
   logic [LOAD_W-1:0] load_ff, load_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   best_type          best_ff, best_in;

   logic selected;
   logic push;
   logic pop;
   logic in_range;
   logic take_own;

   always_comb begin
      selected = (ctl.sel == MY_IDX);
      push     = ctl.push && selected;
      pop      = ctl.pop && selected;

      load_in  = push ? ctl.new_load : load_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end

      // strict compare keeps the lower index on a tie; cell 0 always seeds the chain
      in_range = SRV_CNT_W'(CELL_IDX) < active_count;
      take_own = in_range && ((CELL_IDX == 0) || (load_ff < best_prev.load));
      if (take_own) begin
         best_in.idx  = MY_IDX;
         best_in.load = load_ff;
      end else begin
         best_in = best_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         best_ff  <= '0;
      end else begin
         load_ff  <= load_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem_ff[tail_ff] <= ctl.wdata;
      end
      rd_ff <= queue_mem_ff[head_ff];
   end

   assign best_out   = best_ff;
   assign stat.load  = load_ff;
   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.one   = (count_ff == CNT_W'(1));
   assign stat.rdata = rd_ff;

endmodule

/* hw/rtl/least_loaded_job_dispatch_unit.sv */
// Channel   Ports                                   Direction  Moves
// req       req_valid / req_ready / req_data        in         insert or drain command
// rsp       rsp_valid / rsp_ready / rsp_data        out        assigned, drained, empty, rejected
// csr       psel penable pwrite paddr pwdata prdata in/out     num_servers at byte 0
//
// An insert waits while the running minimum ripples one cell per cycle
// down the row of server cells, and the choice is made after that.
// A drain emits at most 16 ids, each after a pass through the
// registered read port of the server's queue memory; an empty queue gives one empty result.
// Reset clears loads, queue pointers and counts at once; no clearing pass runs.
// A result waiting on rsp_ready holds the sequencer only when a new result is due.
module least_loaded_job_dispatch_unit
   import lldu_pkg::*;
#(
   parameter int MAX_SERVERS = MAX_SERVERS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,

   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,

   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int WAIT_W = $clog2(MAX_SERVERS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_INSERT = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_POP    = 3'd4;
   localparam logic [2:0] ST_GAP    = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic [EMIT_W-1:0]    emit_ff, emit_in;
   logic [SRV_CNT_W-1:0] arrivals_ff, arrivals_in;
   logic [NSRV_W-1:0]    num_servers_ff;
   req_item_type         item_ff, item_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_item_type         out_ff, out_in;

   best_type             chain [MAX_SERVERS + 1];
   cell_stat_type        stat [MAX_SERVERS];
   cell_ctl_type         ctl;
   cell_stat_type        sel_stat;

   logic [SRV_CNT_W-1:0] active_count;
   logic [SRV_IDX_W-1:0] pick;
   logic [SRV_IDX_W-1:0] drain_idx;
   logic [SRV_IDX_W-1:0] sel_idx;
   logic                 opening;
   logic                 drain_oob;
   logic                 slot_free;
   logic                 emit;
   logic                 last_pop;
   logic [LOAD_W:0]      sum;
   logic [LOAD_W-1:0]    sat_load;
   logic                 csr_write;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && !paddr[2];
   assign prdata    = paddr[2] ? '0 : {{(32 - NSRV_W){1'b0}}, num_servers_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         num_servers_ff <= NUM_SERVERS_RST;
      end else if (csr_write) begin
         num_servers_ff <= pwdata[NSRV_W-1:0];
      end
   end

   // row of server cells
   assign chain[0] = '0;

   for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
      lldu_cell #(
         .CELL_IDX    (g),
         .QUEUE_DEPTH (QUEUE_DEPTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .active_count (active_count),
         .ctl          (ctl),
         .best_prev    (chain[g]),
         .best_out     (chain[g + 1]),
         .stat         (stat[g])
      );
   end

   always_comb begin
      if (num_servers_ff == '0) begin
         active_count = SRV_CNT_W'(1);
      end else if ({1'b0, num_servers_ff} > SRV_CNT_W'(MAX_SERVERS)) begin
         active_count = SRV_CNT_W'(MAX_SERVERS);
      end else begin
         active_count = {1'b0, num_servers_ff};
      end

      opening   = arrivals_ff < active_count;
      pick      = opening ? arrivals_ff[SRV_IDX_W-1:0] : chain[MAX_SERVERS].idx;
      drain_idx = {1'b0, item_ff.server_index};
      drain_oob = {2'b00, item_ff.server_index} >= SRV_CNT_W'(MAX_SERVERS);

      sel_idx      = (state_ff == ST_INSERT) ? pick : drain_idx;
      sel_stat     = stat[0];
      for (int i = 1; i < MAX_SERVERS; i++) begin
         if (sel_idx == SRV_IDX_W'(i)) begin
            sel_stat = stat[i];
         end
      end

      sum      = {1'b0, sel_stat.load} + {{(LOAD_W + 1 - TIME_W){1'b0}}, item_ff.job_time};
      sat_load = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
      last_pop = sel_stat.one || (emit_ff == EMIT_W'(RESULT_LIMIT - 1));
   end

   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      emit_in      = emit_ff;
      arrivals_in  = arrivals_ff;
      item_in      = item_ff;
      out_in       = out_ff;
      emit         = 1'b0;
      ctl.sel      = sel_idx;
      ctl.push     = 1'b0;
      ctl.pop      = 1'b0;
      ctl.wdata    = item_ff.customer_id;
      ctl.new_load = sat_load;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               wait_in  = WAIT_W'(MAX_SERVERS);
               state_in = (req_data.cmd == CMD_INSERT) ? ST_SEARCH : ST_CHECK;
            end
         end
         ST_SEARCH: begin
            // let the minimum settle through every cell
            if (wait_ff == '0) begin
               state_in = ST_INSERT;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         ST_INSERT: begin
            if (slot_free) begin
               emit                 = 1'b1;
               out_in.server_number = pick[SRV_NUM_W-1:0];
               out_in.job_id        = item_ff.customer_id;
               out_in.last          = 1'b1;
               if (sel_stat.full) begin
                  out_in.kind        = KIND_REJECTED;
                  out_in.server_load = sel_stat.load;
               end else begin
                  ctl.push           = 1'b1;
                  out_in.kind        = KIND_ASSIGNED;
                  out_in.server_load = sat_load;
                  if (opening) begin
                     arrivals_in = arrivals_ff + 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (drain_oob || sel_stat.empty) begin
               if (slot_free) begin
                  emit                 = 1'b1;
                  out_in.kind          = KIND_EMPTY;
                  out_in.server_number = item_ff.server_index;
                  out_in.job_id        = '0;
                  out_in.server_load   = drain_oob ? '0 : sel_stat.load;
                  out_in.last          = 1'b1;
                  state_in             = ST_IDLE;
               end
            end else begin
               emit_in  = '0;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (slot_free) begin
               emit                 = 1'b1;
               ctl.pop              = 1'b1;
               out_in.kind          = KIND_DRAINED;
               out_in.server_number = item_ff.server_index;
               out_in.job_id        = sel_stat.rdata;
               out_in.server_load   = sel_stat.load;
               out_in.last          = last_pop;
               emit_in              = emit_ff + 1'b1;
               state_in             = last_pop ? ST_IDLE : ST_GAP;
            end
         end
         ST_GAP: begin
            // wait for the read port to follow the new head
            state_in = ST_POP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         emit_ff      <= '0;
         arrivals_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         emit_ff      <= emit_in;
         arrivals_ff  <= arrivals_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* tb/least_loaded_job_dispatch_unit_tb.sv */
`timescale 1ns / 1ps

module least_loaded_job_dispatch_unit_tb;
   import lldu_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   class dispatch_scoreboard;
      logic [LOAD_W-1:0] server_load [MAX_SERVERS_DEF];
      logic [ID_W-1:0]   queued_ids [MAX_SERVERS_DEF][QUEUE_DEPTH_DEF];
      int                queue_head [MAX_SERVERS_DEF];
      int                queue_len [MAX_SERVERS_DEF];
      int                arrivals;
      logic [NSRV_W-1:0] num_servers;
      rsp_item_type      pending_results[$];
      int                mismatches;

      function new();
         for (int s = 0; s < MAX_SERVERS_DEF; s++) begin
            server_load[s] = '0;
            queue_head[s] = 0;
            queue_len[s] = 0;
         end
         arrivals = 0;
         num_servers = NUM_SERVERS_RST;
         mismatches = 0;
      endfunction

      function void set_servers(logic [NSRV_W-1:0] value);
         num_servers = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void push_result(logic [KIND_W-1:0] kind, int srv, logic [ID_W-1:0] id,
                                logic [LOAD_W-1:0] load, logic last);
         rsp_item_type r;
         r.kind = kind;
         r.server_number = srv[SRV_NUM_W-1:0];
         r.job_id = id;
         r.server_load = load;
         r.last = last;
         pending_results.push_back(r);
      endfunction

      // Work out the results that one accepted item causes.
      function void note_job(req_item_type job);
         int              active;
         int              pick;
         int              sidx;
         int              burst;
         bit              opening;
         logic [LOAD_W:0] total;
         if (job.cmd == CMD_INSERT) begin
            active = (num_servers == 0) ? 1 :
                     (num_servers > MAX_SERVERS_DEF) ? MAX_SERVERS_DEF : int'(num_servers);
            opening = arrivals < active;
            if (opening) begin
               pick = arrivals;
            end else begin
               pick = 0;
               for (int j = 1; j < active; j++)
                  if (server_load[j] < server_load[pick]) pick = j;
            end
            if (queue_len[pick] >= QUEUE_DEPTH_DEF) begin
               push_result(KIND_REJECTED, pick, job.customer_id, server_load[pick], 1'b1);
               return;
            end
            queued_ids[pick][(queue_head[pick] + queue_len[pick]) % QUEUE_DEPTH_DEF] =
               job.customer_id;
            queue_len[pick]++;
            total = {1'b0, server_load[pick]} + {{(LOAD_W - TIME_W + 1){1'b0}}, job.job_time};
            server_load[pick] = total[LOAD_W] ? '1 : total[LOAD_W-1:0];
            if (opening && arrivals < MAX_SERVERS_DEF) arrivals++;
            push_result(KIND_ASSIGNED, pick, job.customer_id, server_load[pick], 1'b1);
         end else begin
            sidx = job.server_index;
            if (queue_len[sidx] == 0) begin
               push_result(KIND_EMPTY, sidx, '0, server_load[sidx], 1'b1);
               return;
            end
            burst = (queue_len[sidx] > RESULT_LIMIT) ? RESULT_LIMIT : queue_len[sidx];
            for (int k = 0; k < burst; k++) begin
               push_result(KIND_DRAINED, sidx, queued_ids[sidx][queue_head[sidx]],
                           server_load[sidx], k == burst - 1);
               queue_head[sidx] = (queue_head[sidx] + 1) % QUEUE_DEPTH_DEF;
               queue_len[sidx]--;
            end
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result error: unexpected item kind=%0d srv=%0d id=%h load=%h last=%0d",
                        got.kind, got.server_number, got.job_id, got.server_load, got.last);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.server_number !== want.server_number ||
             got.job_id !== want.job_id || got.server_load !== want.server_load ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result error at %0t: expected kind=%0d srv=%0d id=%h load=%h last=%0d",
                        $time, want.kind, want.server_number, want.job_id,
                        want.server_load, want.last);
               $display("                      got kind=%0d srv=%0d id=%h load=%h last=%0d",
                        got.kind, got.server_number, got.job_id, got.server_load, got.last);
            end
         end
      endfunction

      function void check_register(logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("register error: expected num_servers=%h got %h", want, got);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   dispatch_scoreboard sb;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles = 0;

   least_loaded_job_dispatch_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_job(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic req_item_type make_job(int insert_pct);
      req_item_type job;
      job.cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DRAIN;
      case ($urandom_range(3))
         0: job.job_time = '0;
         1: job.job_time = '1;
         2: job.job_time = TIME_W'($urandom_range(15));
         default: job.job_time = TIME_W'($urandom);
      endcase
      job.customer_id = ID_W'($urandom);
      job.server_index = 3'($urandom_range(7));
      return job;
   endfunction

   function automatic req_item_type job_item(logic cmd, logic [TIME_W-1:0] t,
                                             logic [ID_W-1:0] id, logic [2:0] sidx);
      req_item_type job;
      job.cmd = cmd;
      job.job_time = t;
      job.customer_id = id;
      job.server_index = sidx;
      return job;
   endfunction

   // Present one item and return at the edge where it is taken.
   task automatic send_item(req_item_type job);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= job;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold the sender until every expected result is back.
   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Write num_servers, then read it back.
   task automatic write_servers(logic [NSRV_W-1:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= '0;
      pwdata <= {28'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_servers(value);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.check_register(prdata, {28'd0, value});
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_phase(logic [NSRV_W-1:0] servers, int send_pct, int recv_pct,
                            int count, int insert_pct);
      wait_results();
      write_servers(servers);
      sender_idle_pct = send_pct;
      receiver_stall_pct = recv_pct;
      repeat (count) send_item(make_job(insert_pct));
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // opening round at the reset server count, then ties, drains and empty queues
      send_item(job_item(CMD_INSERT, 16'h0000, 16'h0000, 3'd0));
      send_item(job_item(CMD_INSERT, 16'hFFFF, 16'hFFFF, 3'd7));
      send_item(job_item(CMD_INSERT, 16'h0001, 16'hAAAA, 3'd5));
      send_item(job_item(CMD_INSERT, 16'h8000, 16'h5555, 3'd2));
      send_item(job_item(CMD_INSERT, 16'h7FFF, 16'h0001, 3'd1));
      send_item(job_item(CMD_INSERT, 16'hAAAA, 16'h8000, 3'd6));
      send_item(job_item(CMD_INSERT, 16'h5555, 16'h7FFF, 3'd3));
      send_item(job_item(CMD_INSERT, 16'h0000, 16'h1234, 3'd4));
      send_item(job_item(CMD_INSERT, 16'h0003, 16'h00FF, 3'd0));
      send_item(job_item(CMD_DRAIN, 16'h0000, 16'h0000, 3'd7));
      send_item(job_item(CMD_DRAIN, 16'hFFFF, 16'hFFFF, 3'd7));
      send_item(job_item(CMD_DRAIN, 16'h1234, 16'h4321, 3'd0));
      send_item(job_item(CMD_DRAIN, 16'hFFFF, 16'hFFFF, 3'd5));
      send_item(job_item(CMD_INSERT, 16'h0002, 16'hBEEF, 3'd0));

      run_phase(4'd0, 0, 0, 36, 80);
      run_phase(4'd15, 78, 0, 36, 75);
      run_phase(NSRV_W'($urandom_range(2, 7)), 0, 78, 36, 70);
      run_phase(NSRV_W'($urandom_range(1, 15)), 9, 9, 36, 75);

      wait_results();
      repeat (4 * MAX_SERVERS_DEF) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* least_loaded_job_dispatch_unit.f */
hw/rtl/lldu_pkg.sv
hw/rtl/lldu_cell.sv
hw/rtl/least_loaded_job_dispatch_unit.sv
tb/least_loaded_job_dispatch_unit_tb.sv
